// File: rtl/core/sspp_pkg.sv
// Shared types and constants of the servo status packet parser.
// No dependencies; compile first.
package sspp_pkg;

	localparam int unsigned MaxParamBytes = 64;

	localparam logic [7:0] HeaderByte  = 8'hFF;
	localparam logic [7:0] MinLength   = 8'd2;
	localparam logic [7:0] FrameExtra  = 8'd4;
	localparam int unsigned FirstParam = 5;
	localparam int unsigned SumOffset  = 3;

	typedef enum logic [2:0] {
		V_INCOMPLETE = 3'd0,
		V_OK         = 3'd1,
		V_BAD_HEADER = 3'd2,
		V_TOO_MANY   = 3'd3,
		V_BAD_SUM    = 3'd4
	} verdict_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] id;
		logic [7:0] length;
		logic [7:0] error;
		logic [7:0] sum;
	} parse_state_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] servo_id;
		logic [7:0] servo_error;
		logic [6:0] param_total;
		logic [6:0] frame_size;
		logic       param_valid;
		logic [5:0] param_index;
		logic [7:0] param_data;
	} parse_result_t;

endpackage

// File: rtl/core/sspp_byte_if.sv
// Byte channel into the servo status packet parser: valid/ready plus restart and byte.
// Depends on nothing.
interface sspp_byte_if;
	logic       valid;
	logic       ready;
	logic       restart;
	logic [7:0] rx_byte;

	modport source (output valid, output restart, output rx_byte, input ready);
	modport sink   (input valid, input restart, input rx_byte, output ready);
endinterface

// File: rtl/core/sspp_result_if.sv
// Result channel of the servo status packet parser: valid/ready plus parse result fields.
// Depends on nothing.
interface sspp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;
	logic [7:0] servo_id;
	logic [7:0] servo_error;
	logic [6:0] param_total;
	logic [6:0] frame_size;
	logic       param_valid;
	logic [5:0] param_index;
	logic [7:0] param_data;

	modport source (output valid, output verdict, output servo_id, output servo_error,
		output param_total, output frame_size, output param_valid, output param_index,
		output param_data, input ready);
	modport sink (input valid, input verdict, input servo_id, input servo_error,
		input param_total, input frame_size, input param_valid, input param_index,
		input param_data, output ready);
endinterface

// File: rtl/core/sspp_step.sv
// Per-byte next-state and result logic of the status packet parser.
// Depends on sspp_pkg.
module sspp_step #(
	parameter int unsigned MAX_PARAM_BYTES = sspp_pkg::MaxParamBytes,
	parameter int unsigned CW = $clog2(MAX_PARAM_BYTES + 7)
) (
	input  sspp_pkg::parse_state_t  cur,
	input  logic [CW-1:0]           cnt,
	input  logic                    restart,
	input  logic [7:0]              rx_byte,
	output sspp_pkg::parse_state_t  nxt,
	output logic [CW-1:0]           nxt_cnt,
	output sspp_pkg::parse_result_t res
);

	localparam int unsigned LW = (CW > 9) ? CW : 9;

	sspp_pkg::parse_state_t s;
	logic [CW-1:0]          c;
	logic [LW-1:0]          pos_w;
	logic [LW-1:0]          end_w;
	logic [LW-1:0]          pidx_w;
	logic                   pv;
	logic [5:0]             pidx;
	logic [7:0]             pdat;

	always_comb begin
		s       = restart ? '0 : cur;
		c       = restart ? '0 : cnt;
		nxt     = s;
		nxt_cnt = c;
		pv      = 1'b0;
		pidx    = '0;
		pdat    = '0;
		pos_w   = LW'(c);
		end_w   = LW'(s.length) + LW'(sspp_pkg::SumOffset);
		pidx_w  = pos_w - LW'(sspp_pkg::FirstParam);
		if (s.verdict == sspp_pkg::V_INCOMPLETE) begin
			if (c == CW'(0)) begin
				nxt.sum = rx_byte;
			end else if (c == CW'(1)) begin
				if (s.sum != sspp_pkg::HeaderByte || rx_byte != sspp_pkg::HeaderByte) begin
					nxt.verdict = sspp_pkg::V_BAD_HEADER;
				end
				nxt.sum = '0;
			end else if (c == CW'(2)) begin
				nxt.id  = rx_byte;
				nxt.sum = s.sum + rx_byte;
			end else if (c == CW'(3)) begin
				nxt.length = rx_byte;
				nxt.sum    = s.sum + rx_byte;
				if (rx_byte < sspp_pkg::MinLength) begin
					nxt.verdict = sspp_pkg::V_BAD_HEADER;
				end else if (LW'(rx_byte) > LW'(MAX_PARAM_BYTES + 2)) begin
					nxt.verdict = sspp_pkg::V_TOO_MANY;
				end
			end else if (c == CW'(4)) begin
				nxt.error = rx_byte;
				nxt.sum   = s.sum + rx_byte;
			end else if (pos_w < end_w) begin
				pv      = 1'b1;
				pidx    = pidx_w[5:0];
				pdat    = rx_byte;
				nxt.sum = s.sum + rx_byte;
			end else begin
				nxt.verdict = (~s.sum == rx_byte) ? sspp_pkg::V_OK : sspp_pkg::V_BAD_SUM;
			end
			nxt_cnt = c + CW'(1);
		end
	end

	always_comb begin
		res             = '0;
		res.verdict     = nxt.verdict;
		res.param_valid = pv;
		res.param_index = pidx;
		res.param_data  = pdat;
		if (nxt.verdict == sspp_pkg::V_OK) begin
			res.servo_id    = nxt.id;
			res.servo_error = nxt.error;
			res.param_total = 7'(nxt.length - sspp_pkg::MinLength);
			res.frame_size  = 7'(nxt.length + sspp_pkg::FrameExtra);
		end
	end

endmodule

// File: rtl/core/servo_status_packet_parser.sv
// Top level of the servo status packet parser: parse state and result register.
// Depends on sspp_pkg, sspp_byte_if, sspp_result_if and sspp_step.
//
//   channel | dir | beat payload
//   rx      | in  | restart, rx_byte
//   res     | out | verdict, servo_id, servo_error, param_total, frame_size,
//           |     | param_valid, param_index, param_data
//
// One beat in gives one beat out, in the next cycle; a new byte every cycle while rx.ready is high.
// The single result register after the per-byte logic holds each result beat.
// rx.ready is low only while a result waits and res.ready is low.
// arst_n clears the parse state and empties the result register.
module servo_status_packet_parser #(
	parameter int unsigned MAX_PARAM_BYTES = sspp_pkg::MaxParamBytes
) (
	input  logic          clk,
	input  logic          arst_n,
	sspp_byte_if.sink     rx,
	sspp_result_if.source res
);

	localparam int unsigned CW = $clog2(MAX_PARAM_BYTES + 7);

	sspp_pkg::parse_state_t  state_q;
	logic [CW-1:0]           cnt_q;
	sspp_pkg::parse_state_t  state_nxt;
	logic [CW-1:0]           cnt_nxt;
	sspp_pkg::parse_result_t res_nxt;
	sspp_pkg::parse_result_t res_q;
	logic                    res_valid_q;
	logic                    accept;

	sspp_step #(
		.MAX_PARAM_BYTES(MAX_PARAM_BYTES),
		.CW(CW)
	) u_step (
		.cur(state_q),
		.cnt(cnt_q),
		.restart(rx.restart),
		.rx_byte(rx.rx_byte),
		.nxt(state_nxt),
		.nxt_cnt(cnt_nxt),
		.res(res_nxt)
	);

	assign rx.ready = !res_valid_q || res.ready;
	assign accept   = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				cnt_q       <= cnt_nxt;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.verdict     = res_q.verdict;
	assign res.servo_id    = res_q.servo_id;
	assign res.servo_error = res_q.servo_error;
	assign res.param_total = res_q.param_total;
	assign res.frame_size  = res_q.frame_size;
	assign res.param_valid = res_q.param_valid;
	assign res.param_index = res_q.param_index;
	assign res.param_data  = res_q.param_data;

	a_final_verdict_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !rx.restart && state_q.verdict != sspp_pkg::V_INCOMPLETE
		|=> state_q == $past(state_q) && cnt_q == $past(cnt_q))
		else $error("final verdict state changed without restart");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_PARAM_BYTES + 6)
		else $error("byte count past checksum position");

	a_param_only_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.param_valid |-> res_q.verdict == sspp_pkg::V_INCOMPLETE)
		else $error("parameter beat with final verdict");

	a_fields_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.verdict != sspp_pkg::V_OK
		|-> res_q.servo_id == 8'd0 && res_q.frame_size == 7'd0)
		else $error("packet fields nonzero without ok verdict");

	a_accept_refills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted beat produced no result");

endmodule

// File: tb/servo_status_packet_parser_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for servo_status_packet_parser: byte beats in, one parse result per beat.
// Depends on sspp_pkg, sspp_byte_if, sspp_result_if and the parser itself.
module servo_status_packet_parser_tb;

	localparam int unsigned CycleLimit = 200000;

	typedef struct {
		logic       restart;
		logic [7:0] data;
		logic       drain;
	} byte_beat_t;

	logic clk;
	logic arst_n;

	sspp_byte_if   rx_ch ();
	sspp_result_if res_ch ();

	servo_status_packet_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	byte_beat_t              pending [$];
	sspp_pkg::parse_result_t expected [$];
	logic [7:0]              frame_q [$];

	// parser state as the block should hold it
	logic [8:0]         seen_bytes;
	sspp_pkg::verdict_t held_verdict;
	logic [7:0]         held_id;
	logic [7:0]         held_len;
	logic [7:0]         held_err;
	logic [7:0]         sum_acc;

	int errors;
	int beats_sent;
	int results_seen;
	int param_bytes;
	int verdict_hits [0:4];
	int cycles;
	int gap_left;
	int burst_left;
	int hold_left;
	int phase;
	int stall_mode;
	bit held_off;

	always #2 clk = ~clk;

	task automatic report(input string msg);
		errors++;
		$display("ERROR: %s", msg);
	endtask

	function automatic sspp_pkg::parse_result_t next_result(input logic rst, input logic [7:0] b);
		sspp_pkg::parse_result_t r;
		logic [8:0] pos;
		r = '0;
		if (rst) begin
			seen_bytes = '0;
			held_verdict = sspp_pkg::V_INCOMPLETE;
			held_id = '0;
			held_len = '0;
			held_err = '0;
			sum_acc = '0;
		end
		if (held_verdict == sspp_pkg::V_INCOMPLETE) begin
			pos = seen_bytes;
			if (pos == 0) begin
				sum_acc = b;
			end else if (pos == 1) begin
				if (sum_acc != sspp_pkg::HeaderByte || b != sspp_pkg::HeaderByte)
					held_verdict = sspp_pkg::V_BAD_HEADER;
				sum_acc = '0;
			end else if (pos == 2) begin
				held_id = b;
				sum_acc = sum_acc + b;
			end else if (pos == 3) begin
				held_len = b;
				sum_acc = sum_acc + b;
				if (b < sspp_pkg::MinLength)
					held_verdict = sspp_pkg::V_BAD_HEADER;
				else if (b - sspp_pkg::MinLength > sspp_pkg::MaxParamBytes)
					held_verdict = sspp_pkg::V_TOO_MANY;
			end else if (pos == 4) begin
				held_err = b;
				sum_acc = sum_acc + b;
			end else if (pos < held_len + sspp_pkg::SumOffset) begin
				r.param_valid = 1'b1;
				r.param_index = 6'(pos - sspp_pkg::FirstParam);
				r.param_data = b;
				sum_acc = sum_acc + b;
				param_bytes++;
			end else begin
				held_verdict = (~sum_acc == b) ? sspp_pkg::V_OK : sspp_pkg::V_BAD_SUM;
			end
			seen_bytes = pos + 9'd1;
			if (held_verdict != sspp_pkg::V_INCOMPLETE)
				verdict_hits[held_verdict]++;
		end
		r.verdict = held_verdict;
		if (held_verdict == sspp_pkg::V_OK) begin
			r.servo_id = held_id;
			r.servo_error = held_err;
			r.param_total = 7'(held_len - sspp_pkg::MinLength);
			r.frame_size = 7'(held_len + sspp_pkg::FrameExtra);
		end
		return r;
	endfunction

	task automatic add_beat(input logic r, input logic [7:0] d);
		byte_beat_t bt;
		bt.restart = r;
		bt.data = d;
		bt.drain = 1'b0;
		pending.push_back(bt);
	endtask

	task automatic build_frame(input logic [7:0] id, input logic [7:0] len,
			input logic [7:0] err, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] d;
		frame_q.delete();
		frame_q.push_back(sspp_pkg::HeaderByte);
		frame_q.push_back(sspp_pkg::HeaderByte);
		frame_q.push_back(id);
		frame_q.push_back(len);
		frame_q.push_back(err);
		sum = id + len + err;
		for (int k = sspp_pkg::MinLength; k < len; k++) begin
			d = 8'($urandom_range(0, 255));
			frame_q.push_back(d);
			sum = sum + d;
		end
		if (corrupt)
			frame_q.push_back(~sum ^ 8'($urandom_range(1, 255)));
		else
			frame_q.push_back(~sum);
	endtask

	task automatic push_frame(input int n, input logic rs);
		for (int k = 0; k < n && k < frame_q.size(); k++)
			add_beat(k == 0 ? rs : 1'b0, frame_q[k]);
	endtask

	// driver: present one beat, hold it until taken
	always @(posedge clk) begin : drive
		byte_beat_t nxt;
		logic free;
		if (arst_n) begin
			free = 1'b1;
			if (rx_ch.valid && rx_ch.ready) begin
				expected.push_back(next_result(rx_ch.restart, rx_ch.rx_byte));
				beats_sent++;
			end else if (rx_ch.valid) begin
				free = 1'b0;
			end
			if (free) begin
				if (gap_left != 0) begin
					gap_left--;
					rx_ch.valid <= 1'b0;
				end else if (pending.size() == 0 ||
						(pending[0].drain && expected.size() != 0)) begin
					rx_ch.valid <= 1'b0;
				end else begin
					nxt = pending.pop_front();
					rx_ch.valid <= 1'b1;
					rx_ch.restart <= nxt.restart;
					rx_ch.rx_byte <= nxt.data;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// monitor: check each result beat, drive ready
	always @(posedge clk) begin : watch
		sspp_pkg::parse_result_t got;
		sspp_pkg::parse_result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.verdict = sspp_pkg::verdict_t'(res_ch.verdict);
				got.servo_id = res_ch.servo_id;
				got.servo_error = res_ch.servo_error;
				got.param_total = res_ch.param_total;
				got.frame_size = res_ch.frame_size;
				got.param_valid = res_ch.param_valid;
				got.param_index = res_ch.param_index;
				got.param_data = res_ch.param_data;
				if (expected.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", results_seen));
				end else begin
					want = expected.pop_front();
					if (got.verdict !== want.verdict)
						report($sformatf("result %0d verdict %0d, want %0d",
							results_seen, got.verdict, want.verdict));
					if (got.servo_id !== want.servo_id)
						report($sformatf("result %0d servo_id %0h, want %0h",
							results_seen, got.servo_id, want.servo_id));
					if (got.servo_error !== want.servo_error)
						report($sformatf("result %0d servo_error %0h, want %0h",
							results_seen, got.servo_error, want.servo_error));
					if (got.param_total !== want.param_total)
						report($sformatf("result %0d param_total %0d, want %0d",
							results_seen, got.param_total, want.param_total));
					if (got.frame_size !== want.frame_size)
						report($sformatf("result %0d frame_size %0d, want %0d",
							results_seen, got.frame_size, want.frame_size));
					if (got.param_valid !== want.param_valid)
						report($sformatf("result %0d param_valid %0b, want %0b",
							results_seen, got.param_valid, want.param_valid));
					if (got.param_index !== want.param_index)
						report($sformatf("result %0d param_index %0d, want %0d",
							results_seen, got.param_index, want.param_index));
					if (got.param_data !== want.param_data)
						report($sformatf("result %0d param_data %0h, want %0h",
							results_seen, got.param_data, want.param_data));
				end
				results_seen++;
			end
			phase++;
			if (phase % 64 == 0)
				stall_mode = $urandom_range(0, 3);
			if (!held_off && results_seen == 250) begin
				hold_left = 300;
				held_off = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 1) == 0);
					2: res_ch.ready <= ($urandom_range(0, 4) != 0);
					default: res_ch.ready <= (phase % 4 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("servo_status_packet_parser regression: fail");
			$finish;
		end
	end

	initial begin
		int directed;
		int pick;
		int len;
		clk = 1'b0;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.restart = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;
		seen_bytes = '0;
		held_verdict = sspp_pkg::V_INCOMPLETE;
		held_id = '0;
		held_len = '0;
		held_err = '0;
		sum_acc = '0;
		errors = 0;
		beats_sent = 0;
		results_seen = 0;
		param_bytes = 0;
		cycles = 0;
		gap_left = 0;
		burst_left = 0;
		hold_left = 0;
		phase = 0;
		stall_mode = 0;
		held_off = 1'b0;
		for (int v = 0; v < 5; v++)
			verdict_hits[v] = 0;

		// single byte, then a header that fails, then a byte after the verdict
		add_beat(1'b0, 8'h00);
		add_beat(1'b0, 8'h5A);
		add_beat(1'b0, 8'hFF);
		// restart then second header byte wrong
		add_beat(1'b1, sspp_pkg::HeaderByte);
		add_beat(1'b0, 8'h00);
		// length below two
		add_beat(1'b1, sspp_pkg::HeaderByte);
		add_beat(1'b0, sspp_pkg::HeaderByte);
		add_beat(1'b0, 8'hFE);
		add_beat(1'b0, 8'h01);
		// length far above the parameter limit
		add_beat(1'b1, sspp_pkg::HeaderByte);
		add_beat(1'b0, sspp_pkg::HeaderByte);
		add_beat(1'b0, 8'h00);
		add_beat(1'b0, 8'hFF);
		// good packet without parameters, then a bad checksum
		build_frame(8'hFF, 8'd2, 8'h00, 1'b0);
		push_frame(frame_q.size(), 1'b1);
		build_frame(8'h00, 8'd3, 8'hFF, 1'b1);
		push_frame(frame_q.size(), 1'b1);
		directed = pending.size();

		while (pending.size() < directed + 900) begin
			if (pending.size() == directed || (pending.size() > directed + 600 &&
					pending.size() < directed + 610)) begin
				build_frame(8'($urandom_range(0, 255)), 8'd4, 8'($urandom_range(0, 255)), 1'b0);
				push_frame(frame_q.size(), 1'b1);
				pending[pending.size() - frame_q.size()].drain = 1'b1;
				continue;
			end
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = $urandom_range(0, 19);
				if (len == 0)
					len = sspp_pkg::MaxParamBytes + sspp_pkg::MinLength;
				else if (len == 1)
					len = $urandom_range(sspp_pkg::MinLength,
						sspp_pkg::MaxParamBytes + sspp_pkg::MinLength);
				else
					len = $urandom_range(sspp_pkg::MinLength, 12);
				build_frame(8'($urandom_range(0, 255)), 8'(len), 8'($urandom_range(0, 255)),
					$urandom_range(0, 6) == 0);
				push_frame(frame_q.size(), $urandom_range(0, 19) != 0);
				if ($urandom_range(0, 9) == 0)
					for (int k = $urandom_range(1, 3); k > 0; k--)
						add_beat(1'b0, 8'($urandom_range(0, 255)));
			end else if (pick < 80) begin
				// cut short, next packet restarts mid-way
				build_frame(8'($urandom_range(0, 255)), 8'($urandom_range(2, 12)),
					8'($urandom_range(0, 255)), 1'b0);
				push_frame($urandom_range(1, frame_q.size() - 1), 1'b1);
			end else if (pick < 88) begin
				add_beat(1'b1, sspp_pkg::HeaderByte);
				add_beat(1'b0, sspp_pkg::HeaderByte);
				add_beat(1'b0, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1) == 0)
					add_beat(1'b0, 8'($urandom_range(0, 1)));
				else
					add_beat(1'b0, 8'($urandom_range(
						sspp_pkg::MaxParamBytes + sspp_pkg::MinLength + 1, 255)));
				for (int k = $urandom_range(0, 3); k > 0; k--)
					add_beat(1'b0, 8'($urandom_range(0, 255)));
			end else if (pick < 95) begin
				add_beat(1'b1, 8'($urandom_range(0, 255)));
				for (int k = $urandom_range(0, 7); k > 0; k--)
					add_beat($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					add_beat(1'b1, sspp_pkg::HeaderByte);
					add_beat(1'b0, 8'($urandom_range(0, 254)));
				end else begin
					add_beat(1'b1, 8'($urandom_range(0, 254)));
					add_beat(1'b0, sspp_pkg::HeaderByte);
				end
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending.size() != 0 || rx_ch.valid)
			@(posedge clk);
		while (expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (expected.size() != 0)
			report($sformatf("%0d results never arrived", expected.size()));

		$display("covered %0d bytes, %0d results, %0d parameter bytes", beats_sent,
			results_seen, param_bytes);
		$display("packets ended ok %0d, bad header %0d, too many params %0d, bad checksum %0d",
			verdict_hits[sspp_pkg::V_OK], verdict_hits[sspp_pkg::V_BAD_HEADER],
			verdict_hits[sspp_pkg::V_TOO_MANY], verdict_hits[sspp_pkg::V_BAD_SUM]);
		if (errors == 0)
			$display("servo_status_packet_parser regression: pass");
		else
			$display("servo_status_packet_parser regression: fail");
		$finish;
	end
endmodule

// File: sim.f
rtl/core/sspp_pkg.sv
rtl/core/sspp_byte_if.sv
rtl/core/sspp_result_if.sv
rtl/core/sspp_step.sv
rtl/core/servo_status_packet_parser.sv
tb/servo_status_packet_parser_tb.sv
